/* design/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// Shortest-period unit package
// Shared widths and the sequencer state type of the shortest-period unit.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int SYM_W = 8;
    localparam int LEN_W = 13;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_OUT
    } kmp_state_t;

endpackage

/* design/kmp_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/kmp_shortest_period_unit.sv */
// ----------------------------------------------------------------------------
// Shortest-period unit
// A byte passes through S_READ and S_CMP, repeated for each fallback through the
// border table, before its result is offered; a dropped byte goes straight to S_OUT.
// No new byte is taken until the result is taken, since the compare loop shares
// the symbol and border memories, which have one read port each.
// Reset clears position, match length, overflow flag and the sequencer; the
// memories need no clearing, so the unit is ready right after reset.
// ----------------------------------------------------------------------------
module kmp_shortest_period_unit #(
    parameter int MAX_LEN = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [kmp_pkg::SYM_W-1:0] symbol,
    input  logic                      is_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [kmp_pkg::LEN_W-1:0] period,
    output logic [kmp_pkg::LEN_W-1:0] prefix_length,
    output logic                      string_end,
    output logic                      overflow
);

    import kmp_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW = $clog2(MAX_LEN + 1);

    kmp_state_t state_reg, state_next;

    logic [PW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    match_reg, match_next;
    logic [AW-1:0]    m_reg, m_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;
    logic             ovf_seen_reg, ovf_seen_next;

    logic [LEN_W-1:0] period_reg, period_next;
    logic [LEN_W-1:0] prefix_length_reg, prefix_length_next;
    logic             string_end_reg, string_end_next;
    logic             overflow_reg, overflow_next;

    logic [SYM_W-1:0] sym_rd;
    logic [AW-1:0]    border_rd;
    logic             ram_we;
    logic             accept;
    logic             full;
    logic             sym_eq;
    logic             fall_back;
    logic             hit;
    logic [AW-1:0]    m_final;
    logic [PW-1:0]    pos_inc;

    assign accept    = in_valid && in_ready;
    assign full      = (pos_reg == PW'(MAX_LEN));
    assign sym_eq    = (sym_rd == sym_reg);
    assign fall_back = (m_reg != '0) && !sym_eq;
    assign hit       = (pos_reg != '0) && sym_eq;
    assign m_final   = m_reg + AW'(hit);
    assign pos_inc   = pos_reg + 1'b1;
    assign ram_we    = (state_reg == S_CMP) && !fall_back;

    kmp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_symbol_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (sym_reg),
        .raddr (m_reg),
        .rdata (sym_rd)
    );

    kmp_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LEN)
    ) u_border_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (m_final),
        .raddr (m_reg - 1'b1),
        .rdata (border_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = full ? S_OUT : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = fall_back ? S_READ : S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next           = pos_reg;
        match_next         = match_reg;
        m_next             = m_reg;
        sym_next           = sym_reg;
        last_next          = last_reg;
        ovf_seen_next      = ovf_seen_reg;
        period_next        = period_reg;
        prefix_length_next = prefix_length_reg;
        string_end_next    = string_end_reg;
        overflow_next      = overflow_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_next  = symbol;
                    last_next = is_last;
                    m_next    = (pos_reg == '0) ? '0 : match_reg;
                    if (full)
                    begin
                        period_next        = LEN_W'(pos_reg - PW'(match_reg));
                        prefix_length_next = LEN_W'(pos_reg);
                        string_end_next    = is_last;
                        overflow_next      = 1'b1;
                        ovf_seen_next      = !is_last;
                        if (is_last)
                        begin
                            pos_next   = '0;
                            match_next = '0;
                        end
                    end
                end
            end
            S_READ:
            begin
            end
            S_CMP:
            begin
                if (fall_back)
                begin
                    m_next = border_rd;
                end
                else
                begin
                    period_next        = LEN_W'(pos_inc - PW'(m_final));
                    prefix_length_next = LEN_W'(pos_inc);
                    string_end_next    = last_reg;
                    overflow_next      = ovf_seen_reg;
                    if (last_reg)
                    begin
                        pos_next      = '0;
                        match_next    = '0;
                        ovf_seen_next = 1'b0;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        match_next = m_final;
                    end
                end
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            match_reg    <= '0;
            ovf_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            match_reg    <= match_next;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg             <= m_next;
        sym_reg           <= sym_next;
        last_reg          <= last_next;
        period_reg        <= period_next;
        prefix_length_reg <= prefix_length_next;
        string_end_reg    <= string_end_next;
        overflow_reg      <= overflow_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign period        = period_reg;
    assign prefix_length = prefix_length_reg;
    assign string_end    = string_end_reg;
    assign overflow      = overflow_reg;

endmodule

/* design/kmp_shortest_period_unit_checker.sv */
// ----------------------------------------------------------------------------
// Shortest-period unit checker
// Port-level assertions on the shortest-period unit, bound to its top level.
// ----------------------------------------------------------------------------
module kmp_shortest_period_unit_checker #(
    parameter int MAX_LEN = 4096
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [kmp_pkg::SYM_W-1:0] symbol,
    input logic                      is_last,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [kmp_pkg::LEN_W-1:0] period,
    input logic [kmp_pkg::LEN_W-1:0] prefix_length,
    input logic                      string_end,
    input logic                      overflow
);

    import kmp_pkg::*;

    localparam bit NO_WRAP = (MAX_LEN < (1 << LEN_W));

    // The unit works on one transaction at a time, so it never takes a new
    // byte while a result is on offer.
    a_one_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)
    ) else $error("input accepted while a result is pending");

    a_input_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(symbol) && $stable(is_last))
    ) else $error("waiting input transaction changed");

    a_period_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (!NO_WRAP || ((period != '0) && (period <= prefix_length)))
    ) else $error("period outside 1 to prefix length");

    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(period)
            && $stable(prefix_length) && $stable(string_end) && $stable(overflow))
    ) else $error("stalled result changed");

    a_prefix_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (!NO_WRAP || ((prefix_length != '0)
            && (prefix_length <= LEN_W'(MAX_LEN))))
    ) else $error("prefix length outside capacity");

endmodule

bind kmp_shortest_period_unit kmp_shortest_period_unit_checker #(
    .MAX_LEN (MAX_LEN)
) u_checker (.*);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Shortest-period unit testbench
// Sends byte strings into kmp_shortest_period_unit and checks every result
// against a scoreboard that rebuilds the border table of each string. The run
// covers short directed strings, random periodic strings with mutations,
// and random noise.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kmp_pkg::*;

    localparam int CAPACITY     = 4096;
    localparam int IDLE_LIMIT   = 40000;
    localparam int RANDOM_BYTES = 950;

    typedef logic [SYM_W-1:0] byte_q_t [$];

    typedef struct packed {
        logic [LEN_W-1:0] period;
        logic [LEN_W-1:0] prefix_length;
        logic             string_end;
        logic             overflow;
    } period_result_t;

    class period_scoreboard;
        logic [SYM_W-1:0] stored [CAPACITY];
        int unsigned      borders [CAPACITY];
        int unsigned      fill;
        int unsigned      border_len;
        bit               dropped;
        period_result_t   expected_q [$];
        int               errors;
        int               checked;

        function new();
            fill       = 0;
            border_len = 0;
            dropped    = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void note_byte(logic [SYM_W-1:0] sym, logic last);
            int unsigned    m;
            period_result_t r;
            if (fill < CAPACITY) begin
                m = 0;
                stored[fill] = sym;
                if (fill > 0) begin
                    m = border_len;
                    while (m > 0 && stored[m] != sym)
                        m = borders[m - 1];
                    if (stored[m] == sym)
                        m++;
                end
                borders[fill] = m;
                fill++;
                border_len = m;
            end
            else begin
                dropped = 1'b1;
            end
            r.period        = LEN_W'(fill - border_len);
            r.prefix_length = LEN_W'(fill);
            r.string_end    = last;
            r.overflow      = dropped;
            expected_q.push_back(r);
            if (last) begin
                fill       = 0;
                border_len = 0;
                dropped    = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [LEN_W-1:0] exp_val,
                                    logic [LEN_W-1:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_result(period_result_t act);
            period_result_t exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b/%0b",
                         $time, act.period, act.prefix_length, act.string_end,
                         act.overflow);
            end
            else begin
                exp_r = expected_q.pop_front();
                checked++;
                compare_field("period", exp_r.period, act.period);
                compare_field("prefix_length", exp_r.prefix_length, act.prefix_length);
                compare_field("string_end", LEN_W'(exp_r.string_end),
                              LEN_W'(act.string_end));
                compare_field("overflow", LEN_W'(exp_r.overflow), LEN_W'(act.overflow));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [SYM_W-1:0] symbol    = '0;
    logic             is_last   = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [LEN_W-1:0] period;
    logic [LEN_W-1:0] prefix_length;
    logic             string_end;
    logic             overflow;

    period_scoreboard sb;
    int unsigned      idle_cycles   = 0;
    int unsigned      ready_mode    = 0;
    int unsigned      mode_left     = 0;
    int unsigned      burst_left    = 0;
    int unsigned      bytes_sent    = 0;
    int unsigned      strings_sent  = 0;
    int unsigned      overflow_seen = 0;

    kmp_shortest_period_unit #(
        .MAX_LEN(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .period       (period),
        .prefix_length(prefix_length),
        .string_end   (string_end),
        .overflow     (overflow)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        period_result_t seen;
        if (rst_n && in_valid && in_ready) begin
            sb.note_byte(symbol, is_last);
            bytes_sent++;
        end
        if (rst_n && out_valid && out_ready) begin
            seen.period        = period;
            seen.prefix_length = prefix_length;
            seen.string_end    = string_end;
            seen.overflow      = overflow;
            if (overflow)
                overflow_seen++;
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 256);
        end
        else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (mode_left % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [SYM_W-1:0] sym, input logic last);
        in_valid <= 1'b1;
        symbol   <= sym;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else begin
            burst_left--;
        end
    endtask

    task automatic send_string(input byte_q_t text, input bit no_gaps);
        for (int i = 0; i < text.size(); i++) begin
            if (!no_gaps)
                pace();
            send_byte(text[i], i == text.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        byte_q_t          text;
        byte_q_t          pattern;
        int unsigned      random_bytes;
        int unsigned      len;
        int unsigned      unit;
        logic [SYM_W-1:0] base;
        sb = new();
        random_bytes = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_string('{8'h00}, 1'b0);
        send_string('{8'hFF}, 1'b0);
        send_string('{8'h61, 8'h61, 8'h61, 8'h61}, 1'b1);
        send_string('{8'h61, 8'h61, 8'h62, 8'h61, 8'h61, 8'h61, 8'h62}, 1'b0);
        send_string('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62}, 1'b0);
        send_string('{8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
        wait_drained();

        while (random_bytes < RANDOM_BYTES) begin
            text.delete();
            if ($urandom_range(0, 4) != 0) begin
                unit = $urandom_range(1, 6);
                base = SYM_W'($urandom_range(0, 255));
                pattern.delete();
                for (int i = 0; i < unit; i++)
                    pattern.push_back(base ^ SYM_W'($urandom_range(0, 3)));
                len = $urandom_range(1, 48);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 15) == 0)
                        text.push_back(SYM_W'($urandom));
                    else
                        text.push_back(pattern[i % unit]);
                end
            end
            else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    text.push_back(SYM_W'($urandom));
            end
            send_string(text, $urandom_range(0, 6) == 0);
            random_bytes += len;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();

        send_string('{8'h5A, 8'h5A}, 1'b0);

        wait_drained();
        repeat (20)
            @(posedge clk);

        $display("Sent %0d strings of %0d bytes in total; %0d results checked.",
                 strings_sent, bytes_sent, sb.checked);
        $display("Directed, periodic and noise strings ran; %0d results had overflow set.",
                 overflow_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
